// ----- rtl/core/pcc_pkg.sv -----
// Shared types and constants for the polygon coplanarity checker.
// Used by the front, the queue, the back and the top level; no dependencies.
package pcc_pkg;

   // Fixed widths of the port fields and registers
   localparam int FIELD_W        = 16;
   localparam int COORD_BITS_DEF = 16;
   localparam int TOL_W          = 56;
   localparam int COUNT_W        = 16;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Vertex counts that decide the role of a vertex and the result
   localparam int PLANE_POINTS = 3;
   localparam int CHECK_FROM   = 4;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Configuration port: 64-bit data, registers on 8-byte boundaries
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_SEL_BIT = 3;

   typedef enum logic {
      REG_TOLERANCE = 1'b0,
      REG_FACE_MODE = 1'b1
   } csr_reg_type;

   // What the back has to do with a vertex
   typedef enum logic [2:0] {
      KIND_FIRST  = 3'd0,
      KIND_SECOND = 3'd1,
      KIND_PLANE  = 3'd2,
      KIND_CHECK  = 3'd3,
      KIND_SKIP   = 3'd4
   } vtx_kind_type;

   // Control part of a queued word, formed by the front
   typedef struct packed {
      vtx_kind_type kind;
      logic         last;
      logic         face;
      logic         cnt_lt3;
      logic         cnt_eq3;
      logic         cnt_lt4;
   } vtx_ctrl_type;

endpackage

// ----- rtl/core/pcc_queue.sv -----
// Short first-in first-out queue of words between the front and the back.
// Depends on pcc_pkg for the default depth.
module pcc_queue import pcc_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   // Pointer and fill count update, wrapping at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- rtl/core/pcc_front.sv -----
// Front of the coplanarity checker: accepts vertices, counts them and decides each one's role.
// Depends on pcc_pkg; feeds pcc_queue.
module pcc_front import pcc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [FIELD_W-1:0]        req_coord_x,
   input  logic [FIELD_W-1:0]        req_coord_y,
   input  logic [FIELD_W-1:0]        req_coord_z,
   input  logic                      req_last_vertex,
   input  logic                      face_mode,
   input  logic                      q_full,
   output logic                      q_push,
   output vtx_ctrl_type              q_ctrl,
   output logic [3*COORD_BITS-1:0]   q_coords
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] count_next;
   logic               accept;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;
   assign q_push   = accept;

   // Only the low coordinate bits travel on; the back sign-extends them
   assign q_coords = {req_coord_z[COORD_BITS-1:0], req_coord_y[COORD_BITS-1:0],
                      req_coord_x[COORD_BITS-1:0]};

   // Saturating vertex count including the current vertex
   assign count_next = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;

   // Role of the vertex by its position in the polygon
   always_comb begin
      if (count_ff == COUNT_W'(0)) begin
         q_ctrl.kind = KIND_FIRST;
      end else if (count_ff == COUNT_W'(1)) begin
         q_ctrl.kind = KIND_SECOND;
      end else if (count_ff == COUNT_W'(PLANE_POINTS - 1)) begin
         q_ctrl.kind = KIND_PLANE;
      end else if (!face_mode || count_ff == COUNT_W'(PLANE_POINTS)) begin
         q_ctrl.kind = KIND_CHECK;
      end else begin
         q_ctrl.kind = KIND_SKIP;
      end
      q_ctrl.last    = req_last_vertex;
      q_ctrl.face    = face_mode;
      q_ctrl.cnt_lt3 = (count_next < COUNT_W'(PLANE_POINTS));
      q_ctrl.cnt_eq3 = (count_next == COUNT_W'(PLANE_POINTS));
      q_ctrl.cnt_lt4 = (count_next < COUNT_W'(CHECK_FROM));
   end

   // The count restarts after the last vertex of a polygon
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = req_last_vertex ? '0 : count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/core/pcc_back.sv -----
// Back of the coplanarity checker: forms the plane, checks vertices and issues results.
// Depends on pcc_pkg; takes words from pcc_queue. Three shared multipliers, one sequencer.
module pcc_back import pcc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_empty,
   input  vtx_ctrl_type              q_ctrl,
   input  logic [3*COORD_BITS-1:0]   q_coords,
   output logic                      q_pop,
   input  logic [TOL_W-1:0]          tolerance,
   input  logic                      rsp_pop,
   output logic                      rsp_empty,
   output logic                      rsp_coplanar,
   output logic                      rsp_too_few
);

   // Widths of the exact intermediate values
   localparam int C     = COORD_BITS;
   localparam int DW    = C + 1;          // edge vector component
   localparam int PW    = 2 * DW;         // cross product term
   localparam int NW    = PW + 1;         // normal component
   localparam int PRW   = NW + DW;        // multiplier result
   localparam int OW    = PRW + 2;        // plane offset
   localparam int EW    = PRW + 3;        // plane equation value
   localparam int CMP_W = (EW > TOL_W) ? EW : TOL_W;

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_DIFF     = 11'b000_0000_0010,
      ST_CROSS1   = 11'b000_0000_0100,
      ST_CROSS2   = 11'b000_0000_1000,
      ST_NORM     = 11'b000_0001_0000,
      ST_OFFS_MUL = 11'b000_0010_0000,
      ST_OFFS_SUM = 11'b000_0100_0000,
      ST_CHK_MUL  = 11'b000_1000_0000,
      ST_CHK_SUM  = 11'b001_0000_0000,
      ST_FINISH   = 11'b010_0000_0000,
      ST_SPARE    = 11'b100_0000_0000
   } back_state_type;

   back_state_type state_ff, state_in;

   vtx_ctrl_type          cur_ff;
   logic signed [C-1:0]   v_ff      [3];
   logic signed [C-1:0]   p0_ff     [3];
   logic signed [C-1:0]   p1_ff     [3];
   logic signed [DW-1:0]  u_ff      [3];
   logic signed [DW-1:0]  w_ff      [3];
   logic signed [PRW-1:0] prod_ff   [3];
   logic signed [PW-1:0]  pos_ff    [3];
   logic signed [NW-1:0]  normal_ff [3];
   logic signed [OW-1:0]  offset_ff;
   logic signed [EW-1:0]  e_ff;

   logic signed [NW-1:0]  mul_a [3];
   logic signed [DW-1:0]  mul_b [3];

   logic                  off_plane_ff, off_plane_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  out_cop_ff, out_few_ff;

   logic [EW-1:0]         mag;
   logic                  tol_hit;
   logic                  off_new;
   logic                  cop_new;
   logic                  out_free;
   logic                  advance;

   assign q_pop = (state_ff == ST_IDLE) && !q_empty;

   // Result register parts the back from the consumer
   assign out_free     = !out_valid_ff || rsp_pop;
   assign advance      = (state_ff == ST_FINISH) && (!cur_ff.last || out_free);
   assign rsp_empty    = !out_valid_ff;
   assign rsp_coplanar = out_cop_ff;
   assign rsp_too_few  = out_few_ff;

   // Magnitude of the plane equation against the tolerance
   assign mag     = e_ff[EW-1] ? unsigned'(-e_ff) : unsigned'(e_ff);
   assign tol_hit = CMP_W'(mag) > CMP_W'(tolerance);
   assign off_new = off_plane_ff || ((cur_ff.kind == KIND_CHECK) && tol_hit);

   // Result flags as the polygon closes
   always_comb begin
      if (!cur_ff.face) begin
         cop_new = cur_ff.cnt_lt4 || !off_new;
      end else if (cur_ff.cnt_eq3) begin
         cop_new = 1'b1;
      end else if (cur_ff.cnt_lt3) begin
         cop_new = 1'b0;
      end else begin
         cop_new = !off_new;
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               case (q_ctrl.kind)
                  KIND_PLANE: state_in = ST_DIFF;
                  KIND_CHECK: state_in = ST_CHK_MUL;
                  default:    state_in = ST_FINISH;
               endcase
            end
         end
         ST_DIFF:     state_in = ST_CROSS1;
         ST_CROSS1:   state_in = ST_CROSS2;
         ST_CROSS2:   state_in = ST_NORM;
         ST_NORM:     state_in = ST_OFFS_MUL;
         ST_OFFS_MUL: state_in = ST_OFFS_SUM;
         ST_OFFS_SUM: state_in = ST_FINISH;
         ST_CHK_MUL:  state_in = ST_CHK_SUM;
         ST_CHK_SUM:  state_in = ST_FINISH;
         ST_FINISH: begin
            if (advance) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // Operand selection for the three shared multipliers
   always_comb begin
      case (state_ff)
         ST_CROSS1: begin
            mul_a[0] = NW'(u_ff[1]);  mul_b[0] = w_ff[2];
            mul_a[1] = NW'(w_ff[0]);  mul_b[1] = u_ff[2];
            mul_a[2] = NW'(u_ff[0]);  mul_b[2] = w_ff[1];
         end
         ST_CROSS2: begin
            mul_a[0] = NW'(w_ff[1]);  mul_b[0] = u_ff[2];
            mul_a[1] = NW'(u_ff[0]);  mul_b[1] = w_ff[2];
            mul_a[2] = NW'(w_ff[0]);  mul_b[2] = u_ff[1];
         end
         ST_OFFS_MUL: begin
            for (int i = 0; i < 3; i++) begin
               mul_a[i] = normal_ff[i];
               mul_b[i] = DW'(p1_ff[i]);
            end
         end
         default: begin
            for (int i = 0; i < 3; i++) begin
               mul_a[i] = normal_ff[i];
               mul_b[i] = DW'(v_ff[i]);
            end
         end
      endcase
   end

   // Control registers
   always_comb begin
      off_plane_in = off_plane_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (advance) begin
         off_plane_in = cur_ff.last ? 1'b0 : off_new;
         if (cur_ff.last) begin
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         off_plane_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         off_plane_ff <= off_plane_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               cur_ff <= q_ctrl;
               for (int i = 0; i < 3; i++) begin
                  v_ff[i] <= signed'(q_coords[i*C +: C]);
               end
            end
         end
         ST_DIFF: begin
            for (int i = 0; i < 3; i++) begin
               u_ff[i] <= DW'(p0_ff[i]) - DW'(p1_ff[i]);
               w_ff[i] <= DW'(v_ff[i]) - DW'(p1_ff[i]);
            end
         end
         ST_CROSS1, ST_OFFS_MUL, ST_CHK_MUL: begin
            for (int i = 0; i < 3; i++) begin
               prod_ff[i] <= PRW'(mul_a[i]) * PRW'(mul_b[i]);
            end
         end
         ST_CROSS2: begin
            for (int i = 0; i < 3; i++) begin
               pos_ff[i]  <= signed'(prod_ff[i][PW-1:0]);
               prod_ff[i] <= PRW'(mul_a[i]) * PRW'(mul_b[i]);
            end
         end
         ST_NORM: begin
            for (int i = 0; i < 3; i++) begin
               normal_ff[i] <= NW'(pos_ff[i]) - NW'(signed'(prod_ff[i][PW-1:0]));
            end
         end
         ST_OFFS_SUM: begin
            offset_ff <= -(OW'(prod_ff[0]) + OW'(prod_ff[1]) + OW'(prod_ff[2]));
         end
         ST_CHK_SUM: begin
            e_ff <= EW'(prod_ff[0]) + EW'(prod_ff[1]) + EW'(prod_ff[2]) + EW'(offset_ff);
         end
         ST_FINISH: begin
            if (advance) begin
               if (cur_ff.kind == KIND_FIRST) begin
                  p0_ff <= v_ff;
               end
               if (cur_ff.kind == KIND_SECOND) begin
                  p1_ff <= v_ff;
               end
               if (cur_ff.last) begin
                  out_cop_ff <= cop_new;
                  out_few_ff <= cur_ff.cnt_lt4;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- rtl/core/polygon_coplanarity_check.sv -----
// Coplanarity checker for polygons streamed one vertex per word.
// A stored or skipped vertex only passes idle and finish in the back sequencer; a
// checked one also multiplies and sums, and the third forms the plane on three shared
// multipliers. A two-word queue lets the front accept while the back works; the
// result is written as the back finishes the last vertex.
// Synchronous reset clears the configuration registers, the vertex count, the queue and the result.
module polygon_coplanarity_check import pcc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [FIELD_W-1:0]    req_coord_x,
   input  logic [FIELD_W-1:0]    req_coord_y,
   input  logic [FIELD_W-1:0]    req_coord_z,
   input  logic                  req_last_vertex,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic                  rsp_coplanar,
   output logic                  rsp_too_few,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int QW = $bits(vtx_ctrl_type) + 3 * COORD_BITS;

   logic [TOL_W-1:0]        tolerance_ff;
   logic                    face_mode_ff;
   csr_reg_type             reg_sel;
   logic                    csr_write;

   logic                    fq_push, fq_full, bq_pop, bq_empty;
   vtx_ctrl_type            fq_ctrl, bq_ctrl;
   logic [3*COORD_BITS-1:0] fq_coords, bq_coords;
   logic [QW-1:0]           bq_data;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign reg_sel    = csr_reg_type'(csr_paddr[CSR_SEL_BIT]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= '0;
         face_mode_ff <= 1'b0;
      end else if (csr_write) begin
         case (reg_sel)
            REG_TOLERANCE: tolerance_ff <= csr_pwdata[TOL_W-1:0];
            REG_FACE_MODE: face_mode_ff <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_TOLERANCE: csr_prdata = CSR_DATA_W'(tolerance_ff);
         REG_FACE_MODE: csr_prdata = CSR_DATA_W'(face_mode_ff);
         default:       csr_prdata = '0;
      endcase
   end

   pcc_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .req_last_vertex (req_last_vertex),
      .face_mode       (face_mode_ff),
      .q_full          (fq_full),
      .q_push          (fq_push),
      .q_ctrl          (fq_ctrl),
      .q_coords        (fq_coords)
   );

   pcc_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (fq_push),
      .wr_data ({fq_ctrl, fq_coords}),
      .full    (fq_full),
      .pop     (bq_pop),
      .rd_data (bq_data),
      .empty   (bq_empty)
   );

   assign bq_ctrl   = vtx_ctrl_type'(bq_data[QW-1 -: $bits(vtx_ctrl_type)]);
   assign bq_coords = bq_data[3*COORD_BITS-1:0];

   pcc_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (bq_empty),
      .q_ctrl       (bq_ctrl),
      .q_coords     (bq_coords),
      .q_pop        (bq_pop),
      .tolerance    (tolerance_ff),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_coplanar (rsp_coplanar),
      .rsp_too_few  (rsp_too_few)
   );

endmodule

// ----- tb/tb_polygon_coplanarity_check.sv -----
// Self-checking testbench for the polygon coplanarity checker.
// Depends on pcc_pkg and polygon_coplanarity_check; predicts untyped verdicts itself.
module tb_polygon_coplanarity_check;
   import pcc_pkg::*;

   // Verdict word as it leaves the block.
   typedef struct packed {
      logic coplanar;
      logic too_few;
   } verdict_type;

   typedef enum logic [1:0] {
      ROW_VERTEX,
      ROW_TOLERANCE,
      ROW_FACE_MODE
   } row_kind_type;

   // One row of the directed table: a vertex word or a register write.
   typedef struct packed {
      row_kind_type       kind;
      logic [FIELD_W-1:0] x;
      logic [FIELD_W-1:0] y;
      logic [FIELD_W-1:0] z;
      logic               last;
      logic               typed;
      verdict_type        want;
      logic [63:0]        value;
   } row_type;

   localparam int     N_ROWS        = 27;
   localparam int     PHASE_ITEMS   = 300;
   localparam int     DRAIN_CYCLES  = 40;
   localparam int     HOLD_CYCLES   = 300;
   localparam longint TOL_ONES      = 64'h00ff_ffff_ffff_ffff;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [FIELD_W-1:0]    req_coord_x = '0;
   logic [FIELD_W-1:0]    req_coord_y = '0;
   logic [FIELD_W-1:0]    req_coord_z = '0;
   logic                  req_last_vertex = 1'b0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic                  rsp_coplanar;
   logic                  rsp_too_few;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Predictor state: stored points, plane, vertex count and off-plane flag.
   longint      pl_first [3] = '{0, 0, 0};
   longint      pl_second [3] = '{0, 0, 0};
   longint      pl_normal [3] = '{0, 0, 0};
   longint      pl_offset = 0;
   int unsigned pl_count = 0;
   bit          pl_off = 1'b0;
   logic [55:0] tol_reg = '0;
   logic        face_reg = 1'b0;

   verdict_type verdict_q [$];
   int       failures = 0;
   int       verdicts_checked = 0;
   int       vertices_sent = 0;
   int       full_stall_cycles = 0;
   int       send_idle_pct = 19;
   int       recv_idle_pct = 47;
   bit       hold_off_req = 1'b0;

   row_type directed_rows [N_ROWS] = '{
      // Reset values: zero tolerance, polygon mode. One vertex, then two.
      '{ROW_VERTEX, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 2'b11, 64'd0},
      '{ROW_VERTEX, 16'h7fff, 16'h8000, 16'h7fff, 1'b0, 1'b0, 2'b00, 64'd0},
      '{ROW_VERTEX, 16'h8000, 16'h7fff, 16'h8000, 1'b1, 1'b1, 2'b11, 64'd0},
      // Corners of the coordinate range give the widest normal and offset.
      '{ROW_VERTEX, 16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0, 2'b00, 64'd0},
      '{ROW_VERTEX, 16'h7fff, 16'h8000, 16'h7fff, 1'b0, 1'b0, 2'b00, 64'd0},
      '{ROW_VERTEX, 16'h8000, 16'h7fff, 16'h7fff, 1'b0, 1'b0, 2'b00, 64'd0},
      '{ROW_VERTEX, 16'h7fff, 16'h7fff, 16'h8000, 1'b1, 1'b0, 2'b00, 64'd0},
      // Colinear first three vertices: the normal is zero.
      '{ROW_VERTEX, 16'h0001, 16'h0001, 16'h0001, 1'b0, 1'b0, 2'b00, 64'd0},
      '{ROW_VERTEX, 16'h0002, 16'h0002, 16'h0002, 1'b0, 1'b0, 2'b00, 64'd0},
      '{ROW_VERTEX, 16'h0003, 16'h0003, 16'h0003, 1'b0, 1'b0, 2'b00, 64'd0},
      '{ROW_VERTEX, 16'h7fff, 16'h8000, 16'h1234, 1'b1, 1'b0, 2'b00, 64'd0},
      // Largest tolerance lets a far vertex pass.
      '{ROW_TOLERANCE, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0, 2'b00, 64'h00ff_ffff_ffff_ffff},
      '{ROW_VERTEX, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 2'b00, 64'd0},
      '{ROW_VERTEX, 16'h0001, 16'h0000, 16'h0000, 1'b0, 1'b0, 2'b00, 64'd0},
      '{ROW_VERTEX, 16'h0000, 16'h0001, 16'h0000, 1'b0, 1'b0, 2'b00, 64'd0},
      '{ROW_VERTEX, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1, 1'b0, 2'b00, 64'd0},
      // Mode switched to face inside a polygon: the fifth vertex goes unchecked.
      '{ROW_TOLERANCE, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0, 2'b00, 64'd0},
      '{ROW_VERTEX, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 2'b00, 64'd0},
      '{ROW_VERTEX, 16'h0001, 16'h0000, 16'h0000, 1'b0, 1'b0, 2'b00, 64'd0},
      '{ROW_VERTEX, 16'h0000, 16'h0001, 16'h0000, 1'b0, 1'b0, 2'b00, 64'd0},
      '{ROW_VERTEX, 16'h0003, 16'h0004, 16'h0000, 1'b0, 1'b0, 2'b00, 64'd0},
      '{ROW_FACE_MODE, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0, 2'b00, 64'd1},
      '{ROW_VERTEX, 16'h0009, 16'h0009, 16'h0009, 1'b1, 1'b0, 2'b00, 64'd0},
      // Face mode: one vertex is not a face, three are.
      '{ROW_VERTEX, 16'h0001, 16'h0002, 16'h0003, 1'b1, 1'b1, 2'b01, 64'd0},
      '{ROW_VERTEX, 16'h0001, 16'h0000, 16'h0000, 1'b0, 1'b0, 2'b00, 64'd0},
      '{ROW_VERTEX, 16'h0000, 16'h0001, 16'h0000, 1'b0, 1'b0, 2'b00, 64'd0},
      '{ROW_VERTEX, 16'h0000, 16'h0000, 16'h0001, 1'b1, 1'b1, 2'b11, 64'd0}
   };

   polygon_coplanarity_check i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .req_last_vertex (req_last_vertex),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_coplanar    (rsp_coplanar),
      .rsp_too_few     (rsp_too_few),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #5 clock = ~clock;

   // Advances the plane state by one vertex and forms the verdict on the last one.
   function automatic void predict_verdict(input logic [FIELD_W-1:0] x, y, z,
                                           input logic last,
                                           output bit has_verdict, output verdict_type vd);
      longint      v [3];
      longint      ux, uy, uz, wx, wy, wz, resid, mag;
      int unsigned idx, n;
      v[0] = longint'($signed(x));
      v[1] = longint'($signed(y));
      v[2] = longint'($signed(z));
      idx = pl_count;
      if (idx == 0) begin
         pl_first = v;
      end else if (idx == 1) begin
         pl_second = v;
      end else if (idx == PLANE_POINTS - 1) begin
         // Normal is (P0 - P1) x (P2 - P1); the offset puts P1 on the plane.
         ux = pl_first[0] - pl_second[0];
         uy = pl_first[1] - pl_second[1];
         uz = pl_first[2] - pl_second[2];
         wx = v[0] - pl_second[0];
         wy = v[1] - pl_second[1];
         wz = v[2] - pl_second[2];
         pl_normal[0] = uy * wz - wy * uz;
         pl_normal[1] = wx * uz - ux * wz;
         pl_normal[2] = ux * wy - wx * uy;
         pl_offset = -(pl_normal[0] * pl_second[0] + pl_normal[1] * pl_second[1] +
                       pl_normal[2] * pl_second[2]);
      end else if (!face_reg || idx == PLANE_POINTS) begin
         resid = pl_normal[0] * v[0] + pl_normal[1] * v[1] + pl_normal[2] * v[2] + pl_offset;
         mag = (resid < 0) ? -resid : resid;
         if (mag > longint'({8'd0, tol_reg}))
            pl_off = 1'b1;
      end
      n = (idx < COUNT_MAX) ? idx + 1 : COUNT_MAX;
      pl_count = n;
      has_verdict = last;
      vd = '0;
      if (last) begin
         vd.too_few = (n < CHECK_FROM);
         if (!face_reg)
            vd.coplanar = (n < CHECK_FROM) ? 1'b1 : !pl_off;
         else if (n == PLANE_POINTS)
            vd.coplanar = 1'b1;
         else if (n < PLANE_POINTS)
            vd.coplanar = 1'b0;
         else
            vd.coplanar = !pl_off;
         pl_count = 0;
         pl_off = 1'b0;
      end
   endfunction

   // Offers one vertex word until it is taken, then maybe leaves a gap.
   task automatic send_vertex(input logic [FIELD_W-1:0] x, y, z, input logic last,
                              input bit typed, input verdict_type want);
      bit          has;
      verdict_type vd;
      req_push <= 1'b1;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      req_last_vertex <= last;
      do begin
         @(posedge clock);
         if (req_full)
            full_stall_cycles++;
      end while (req_full);
      vertices_sent++;
      predict_verdict(x, y, z, last, has, vd);
      if (has)
         verdict_q.push_back(typed ? want : vd);
      if ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Stops the input, waits for every verdict and lets the back sequencer settle.
   task automatic wait_idle();
      req_push <= 1'b0;
      while (verdict_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write followed by a read-back of the same register.
   task automatic write_csr(input csr_reg_type sel, input logic [63:0] value);
      wait_idle();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(int'(sel) << CSR_SEL_BIT);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (sel == REG_TOLERANCE)
         tol_reg = value[55:0];
      else
         face_reg = value[0];
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (sel == REG_TOLERANCE && csr_prdata[55:0] !== tol_reg) begin
         $error("tolerance: expected %0h, got %0h", tol_reg, csr_prdata[55:0]);
         failures++;
      end
      if (sel == REG_FACE_MODE && csr_prdata[0] !== face_reg) begin
         $error("face_mode: expected %0b, got %0b", face_reg, csr_prdata[0]);
         failures++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // One random polygon: mostly planar with random content, some noisy or broken.
   task automatic send_random_polygon(output int nvert);
      int                 flavour, pick, len, k, i, s, t, ax;
      int                 base [3], u [3], w [3], p [3];
      logic [FIELD_W-1:0] c [3];
      logic [FIELD_W-1:0] level;
      flavour = $urandom_range(9);
      pick = $urandom_range(99);
      if (pick < 12)
         len = $urandom_range(1, 3);
      else if (pick < 88)
         len = $urandom_range(4, 8);
      else
         len = $urandom_range(9, 24);
      for (i = 0; i < 3; i++) begin
         base[i] = $urandom_range(0, 2000) - 1000;
         u[i] = $urandom_range(0, 120) - 60;
         w[i] = $urandom_range(0, 120) - 60;
      end
      ax = $urandom_range(2);
      level = 16'($urandom());
      for (k = 0; k < len; k++) begin
         if (flavour <= 5) begin
            // Points spanned by the edge vectors u and w, some nudged off the plane.
            s = (k == 0) ? 1 : (k <= 2) ? 0 : $urandom_range(0, 80) - 40;
            t = (k == 2) ? 1 : (k <= 1) ? 0 : $urandom_range(0, 80) - 40;
            for (i = 0; i < 3; i++)
               p[i] = base[i] + s * u[i] + t * w[i];
            if (flavour >= 4 && k >= 3 && $urandom_range(3) == 0)
               p[$urandom_range(2)] += $urandom_range(0, 4) - 2;
            for (i = 0; i < 3; i++)
               c[i] = 16'(p[i]);
         end else begin
            // Full-range coordinates, either on an axis plane or anywhere.
            for (i = 0; i < 3; i++)
               c[i] = 16'($urandom());
            if (flavour <= 7) begin
               c[ax] = level;
               if (flavour == 7 && k >= 3 && $urandom_range(4) == 0)
                  c[ax] = level + 16'd1;
            end
         end
         send_vertex(c[0], c[1], c[2], (k == len - 1), 1'b0, '0);
      end
      nvert = len;
   endtask

   // One setting of the registers and the idling, with an optional long hold-off.
   task automatic run_phase(input logic [63:0] tol, input logic face, input int spct, rpct,
                            input bit squeeze);
      int sent, got;
      write_csr(REG_TOLERANCE, tol);
      write_csr(REG_FACE_MODE, {63'd0, face});
      send_idle_pct = spct;
      recv_idle_pct = rpct;
      if (squeeze) begin
         // Single-vertex polygons pile up while the receiver holds off.
         hold_off_req = 1'b1;
         for (sent = 0; sent < 12; sent++)
            send_vertex(16'($urandom()), 16'($urandom()), 16'($urandom()), 1'b1, 1'b0, '0);
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         send_random_polygon(got);
         sent += got;
      end
   endtask

   // Receiver: pops at random, and holds off for a long stretch on request.
   initial begin : receiver
      int held;
      while (reset)
         @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_pop <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++)
               @(posedge clock);
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Every accepted verdict word is compared with the oldest prediction.
   always @(posedge clock) begin : verdict_check
      verdict_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (verdict_q.size() == 0) begin
            $error("verdict word with none outstanding: coplanar=%0b too_few=%0b",
                   rsp_coplanar, rsp_too_few);
            failures++;
         end else begin
            want = verdict_q.pop_front();
            verdicts_checked++;
            if (rsp_coplanar !== want.coplanar) begin
               $error("coplanar: expected %0b, got %0b", want.coplanar, rsp_coplanar);
               failures++;
            end
            if (rsp_too_few !== want.too_few) begin
               $error("too_few: expected %0b, got %0b", want.too_few, rsp_too_few);
               failures++;
            end
         end
      end
   end

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table.
      foreach (directed_rows[r]) begin
         case (directed_rows[r].kind)
            ROW_TOLERANCE: begin
               write_csr(REG_TOLERANCE, directed_rows[r].value);
            end
            ROW_FACE_MODE: begin
               write_csr(REG_FACE_MODE, directed_rows[r].value);
            end
            default: begin
               send_vertex(directed_rows[r].x, directed_rows[r].y, directed_rows[r].z,
                           directed_rows[r].last, directed_rows[r].typed,
                           directed_rows[r].want);
            end
         endcase
      end

      // Random phases over several register settings and idling patterns.
      run_phase(64'd0, 1'b0, 19, 47, 1'b0);
      run_phase(64'($urandom_range(1, 200000)), 1'b1, 19, 47, 1'b0);
      run_phase(TOL_ONES, 1'b0, 47, 19, 1'b0);
      run_phase({$urandom(), $urandom()}, 1'b1, 47, 19, 1'b0);
      run_phase(64'd0, 1'b1, 0, 0, 1'b1);
      run_phase(64'($urandom()), 1'b0, 0, 0, 1'b0);

      wait_idle();
      $display("Checked %0d verdicts from %0d vertex words; input stalled on full for %0d cycles.",
               verdicts_checked, vertices_sent, full_stall_cycles);
      if (failures == 0)
         $display("polygon_coplanarity_check regression: pass");
      else
         $display("polygon_coplanarity_check regression: fail");
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin : watchdog
      #3000000;
      $display("polygon_coplanarity_check regression: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/pcc_pkg.sv
rtl/core/pcc_queue.sv
rtl/core/pcc_front.sv
rtl/core/pcc_back.sv
rtl/core/polygon_coplanarity_check.sv
tb/tb_polygon_coplanarity_check.sv
